// File: rtl/core/assert_macros.svh
// assertion helpers, clocked on the rising edge and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property check
`define CHK_PROP(label, clk_s, rstn_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/okeof_pkg.sv
`default_nettype none
package okeof_pkg;

  // parse phases of the ok layout
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ROWS_PFX = 3'd1,
    PH_ROWS_INT = 3'd2,
    PH_INS_PFX  = 3'd3,
    PH_INS_INT  = 3'd4,
    PH_STATUS   = 3'd5,
    PH_WARN     = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  localparam logic [7:0] HDR_OK      = 8'h00;
  localparam logic [7:0] HDR_EOF     = 8'hFE;
  localparam logic [7:0] LEN_NULL    = 8'hFB;
  localparam logic [7:0] LEN_2B      = 8'hFC;
  localparam logic [7:0] LEN_3B      = 8'hFD;
  localparam logic [7:0] LEN_8B      = 8'hFE;
  localparam logic [7:0] LEN_ERR     = 8'hFF;
  localparam logic [3:0] EOF_MAX_LEN = 4'd9;
  localparam logic [3:0] EOF_MIN_LEN = 4'd5;
  localparam logic [3:0] WORD_BYTES  = 4'd2;

  localparam int unsigned OUT_DATA_W = 160;

endpackage
`default_nettype wire

// File: rtl/core/ok_eof_packet_parser.sv
// OK / EOF response packet parser
// in_*  : one packet byte per transfer, header byte first; in_tlast marks the
//         final byte of the packet
// out_* : one result per packet, presented the cycle after the last byte is
//         taken; every other byte gives no result
// throughput: one byte per cycle, back to back, unless a result waits for out_tready;
// each byte updates the parse state through a single level of decode logic into the state registers
// the packet is read two ways at once: payload bytes 1..4 are kept for an
// eof packet (header 0xFE, under 9 bytes), and the ok layout is decoded in
// parallel; the choice is made at the last byte
// a registered result stage sits between the two sides: while a result waits
// for out_tready, in_tready is low and no byte is taken; with out_tready high
// a byte can be taken in every cycle, including the first byte of the next
// packet right after a last byte
// reset (rst_n low, synchronous) clears the parse state and drops out_tvalid;
// the state also returns to its reset value after every last byte
`default_nettype none
`include "assert_macros.svh"
module ok_eof_packet_parser (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // data_byte
  input  wire logic                             in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // affected_rows[63:0], last_insert_id[127:64], server_status[143:128],
  // warning_count[159:144]
  output logic [okeof_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                            out_tuser   // packet_kind, parse_error
);
  import okeof_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [3:0]  left_r, left_nxt;
  logic [3:0]  width_r, width_nxt;
  logic [63:0] rows_r, rows_nxt;
  logic [63:0] ins_r, ins_nxt;
  logic [15:0] status_r, status_nxt;
  logic [15:0] warn_r, warn_nxt;
  logic [31:0] early_r, early_nxt;
  logic        err_r, err_nxt;

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic        in_xfer;
  logic [7:0]  b;
  logic [3:0]  pfx_len;
  logic        pfx_err;
  logic        pfx_short;
  logic [3:0]  left_dec;
  logic [2:0]  int_pos;
  logic [63:0] int_lane;
  logic [15:0] word_lane;
  logic [1:0]  early_pos;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign b         = in_tdata;

  // length prefix decode
  always_comb begin
    pfx_len   = 4'd0;
    pfx_err   = 1'b0;
    pfx_short = 1'b0;
    if (b < LEN_NULL) begin
      pfx_short = 1'b1;
    end else begin
      unique case (b)
        LEN_NULL: pfx_len = 4'd0;
        LEN_2B:   pfx_len = 4'd2;
        LEN_3B:   pfx_len = 4'd3;
        LEN_8B:   pfx_len = 4'd8;
        LEN_ERR:  pfx_err = 1'b1;
        default:  pfx_len = 4'd0;
      endcase
    end
  end

  assign left_dec  = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;
  assign int_pos   = 3'(width_r - left_r);
  assign int_lane  = {56'd0, b} << {int_pos, 3'b000};
  assign word_lane = {8'd0, b} << {~left_r[1], 3'b000};
  assign early_pos = 2'(seen_r - 4'd1);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    left_nxt   = left_r;
    width_nxt  = width_r;
    rows_nxt   = rows_r;
    ins_nxt    = ins_r;
    status_nxt = status_r;
    warn_nxt   = warn_r;
    err_nxt    = err_r;
    early_nxt  = early_r;
    seen_nxt   = (seen_r < EOF_MAX_LEN) ? seen_r + 4'd1 : EOF_MAX_LEN;

    if (seen_r >= 4'd1 && seen_r <= 4'd4) begin
      early_nxt = early_r | ({24'd0, b} << {early_pos, 3'b000});
    end

    unique case (phase_r)
      PH_HEADER: begin
        header_nxt = b;
        phase_nxt  = PH_ROWS_PFX;
      end
      PH_ROWS_PFX, PH_INS_PFX: begin
        if (phase_r == PH_ROWS_PFX) begin
          rows_nxt = pfx_short ? {56'd0, b} : 64'd0;
        end else begin
          ins_nxt = pfx_short ? {56'd0, b} : 64'd0;
        end
        if (pfx_err) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (pfx_len != 4'd0) begin
          width_nxt = pfx_len;
          left_nxt  = pfx_len;
          phase_nxt = (phase_r == PH_ROWS_PFX) ? PH_ROWS_INT : PH_INS_INT;
        end else if (phase_r == PH_ROWS_PFX) begin
          phase_nxt = PH_INS_PFX;
        end else begin
          phase_nxt = PH_STATUS;
          left_nxt  = WORD_BYTES;
        end
      end
      PH_ROWS_INT, PH_INS_INT: begin
        if (phase_r == PH_ROWS_INT) begin
          rows_nxt = rows_r | int_lane;
        end else begin
          ins_nxt = ins_r | int_lane;
        end
        left_nxt = left_dec;
        if (left_dec == 4'd0) begin
          if (phase_r == PH_ROWS_INT) begin
            phase_nxt = PH_INS_PFX;
          end else begin
            phase_nxt = PH_STATUS;
            left_nxt  = WORD_BYTES;
          end
        end
      end
      PH_STATUS, PH_WARN: begin
        if (phase_r == PH_STATUS) begin
          status_nxt = status_r | word_lane;
        end else begin
          warn_nxt = warn_r | word_lane;
        end
        left_nxt = left_dec;
        if (left_dec == 4'd0) begin
          if (phase_r == PH_STATUS) begin
            phase_nxt = PH_WARN;
            left_nxt  = WORD_BYTES;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: phase_nxt = PH_DONE;
    endcase
  end

  // result, taken from the state after the last byte
  always_comb begin
    out_data_nxt = '0;
    out_user_nxt = 2'b00;
    if (header_nxt == HDR_EOF && seen_nxt < EOF_MAX_LEN) begin
      out_user_nxt[0] = 1'b1;
      if (seen_nxt < EOF_MIN_LEN) begin
        out_user_nxt[1] = 1'b1;
      end else begin
        out_data_nxt[159:144] = early_nxt[15:0];
        out_data_nxt[143:128] = early_nxt[31:16];
      end
    end else if ((header_nxt != HDR_OK && header_nxt != HDR_EOF) || err_nxt ||
                 phase_nxt != PH_DONE) begin
      out_user_nxt[1] = 1'b1;
    end else begin
      out_data_nxt = {warn_nxt, status_nxt, ins_nxt, rows_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_tlast)) begin
      phase_r  <= PH_HEADER;
      header_r <= 8'd0;
      seen_r   <= 4'd0;
      left_r   <= 4'd0;
      width_r  <= 4'd0;
      rows_r   <= 64'd0;
      ins_r    <= 64'd0;
      status_r <= 16'd0;
      warn_r   <= 16'd0;
      early_r  <= 32'd0;
      err_r    <= 1'b0;
    end else if (in_xfer) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      seen_r   <= seen_nxt;
      left_r   <= left_nxt;
      width_r  <= width_nxt;
      rows_r   <= rows_nxt;
      ins_r    <= ins_nxt;
      status_r <= status_nxt;
      warn_r   <= warn_nxt;
      early_r  <= early_nxt;
      err_r    <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload of the result stage
  always_ff @(posedge clk) begin
    if (in_xfer && in_tlast) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `CHK_NEXT(a_last_gives_result, clk, rst_n, in_xfer && in_tlast, out_tvalid)
  `CHK_NEXT(a_last_clears_state, clk, rst_n, in_xfer && in_tlast,
            phase_r == PH_HEADER && seen_r == 4'd0 && !err_r)
  `CHK_PROP(a_error_zero_fields, clk, rst_n,
            out_tvalid && out_tuser[1] |-> out_tdata == '0)
  `CHK_PROP(a_eof_no_counts, clk, rst_n,
            out_tvalid && out_tuser[0] |-> out_tdata[127:0] == 128'd0)
  `CHK_PROP(a_seen_saturates, clk, rst_n, seen_r <= EOF_MAX_LEN)

endmodule
`default_nettype wire
